// ----- hw/rtl/rrw_pkg.sv -----
// rrw_pkg: types and codes shared by the receive window modules.
// No dependencies.
package rrw_pkg;

    localparam int unsigned SEQ_W = 32;

    typedef enum logic [1:0] {
        FUNC_MSG = 2'd0,
        FUNC_ACK = 2'd1,
        FUNC_UNK = 2'd2,
        FUNC_RSV = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        VERD_ACCEPT  = 3'd0,
        VERD_UNKNOWN = 3'd1,
        VERD_OUTSIDE = 3'd2,
        VERD_DUP     = 3'd3,
        VERD_ACK     = 3'd4,
        VERD_BADTYPE = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [1:0]  func;
        logic        sender_known;
        logic [3:0]  peer;
        logic [31:0] seq_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        deliver;
        logic [6:0]  window_advance;
        logic [31:0] next_expected_out;
        logic [6:0]  newly_acked;
    } t_out_item;

    // request handed from the front classifier to the back executor
    typedef struct packed {
        logic        known;
        logic [1:0]  func;
        logic [3:0]  peer;
        logic [31:0] seq_value;
    } t_req;

endpackage

// ----- hw/rtl/rrw_front.sv -----
// rrw_front: accepts fragments and classifies them into requests.
// Depends on rrw_pkg.
module rrw_front #(
    parameter int unsigned PEERS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  rrw_pkg::t_in_item i_item,
    output logic              o_req_valid,
    input  logic              i_req_ready,
    output rrw_pkg::t_req     o_req
);
    import rrw_pkg::*;

    logic  r_valid;
    t_req  r_req;
    t_req  n_req;

    assign full        = r_valid && !i_req_ready;
    assign o_req_valid = r_valid;
    assign o_req       = r_req;

    always_comb begin
        n_req.known     = i_item.sender_known && (32'(i_item.peer) < PEERS);
        n_req.func      = i_item.func;
        n_req.peer      = i_item.peer;
        n_req.seq_value = i_item.seq_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (push && !full) begin
            r_valid <= 1'b1;
        end else if (i_req_ready) begin
            r_valid <= 1'b0;
        end
        if (push && !full) begin
            r_req <= n_req;
        end
    end
endmodule

// ----- hw/rtl/rrw_back.sv -----
// rrw_back: per-peer window state and request execution; output register.
// Depends on rrw_pkg.
module rrw_back #(
    parameter int unsigned WINDOW = 32,
    parameter int unsigned PEERS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  rrw_pkg::t_req      i_req,
    output logic               empty,
    input  logic               pop,
    output rrw_pkg::t_out_item o_item
);
    import rrw_pkg::*;

    localparam int unsigned SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned NP = (PEERS < 16) ? PEERS : 16;
    localparam int unsigned PW = (NP > 1) ? $clog2(NP) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SLIDE = 3'b010,
        ST_DONE  = 3'b100
    } t_state;

    logic [31:0]     r_next [NP];
    logic [SW-1:0]   r_left [NP];
    logic [WINDOW-1:0] r_occ [NP];
    logic [31:0]     r_ack [NP];

    t_state    r_state;
    logic [PW-1:0] r_peer;
    logic [6:0]    r_adv;
    logic          r_out_valid;
    t_out_item     r_out;
    t_out_item     n_out;
    logic          n_out_valid;

    logic [PW-1:0] cur_peer;
    logic [31:0]   d_msg, d_ack;
    logic [SW:0]   slot_sum;
    logic [SW-1:0] slot;
    logic [6:0]    acked;
    logic          take;
    logic          is_new;

    assign cur_peer    = i_req.peer[PW-1:0];
    assign d_msg       = i_req.seq_value - r_next[cur_peer];
    assign d_ack       = i_req.seq_value - r_ack[cur_peer];
    // only used when d_msg is inside the window, so one subtract wraps it
    assign slot_sum    = {1'b0, d_msg[SW-1:0]} + {1'b0, r_left[cur_peer]};
    assign slot        = (32'(slot_sum) >= WINDOW) ? SW'(32'(slot_sum) - WINDOW) :
                         slot_sum[SW-1:0];
    assign acked       = (d_ack == 32'd0 || d_ack[31]) ? 7'd0 :
                         (d_ack < WINDOW) ? 7'(d_ack) : 7'(WINDOW);
    assign o_req_ready = (r_state == ST_IDLE) && (!r_out_valid || pop);
    assign empty       = !r_out_valid;
    assign o_item      = r_out;
    assign take        = (r_state == ST_IDLE) && i_req_valid && o_req_ready;
    assign is_new      = i_req.known && (i_req.func == FUNC_MSG) && (d_msg < WINDOW) &&
                         !r_occ[cur_peer][slot];

    always_comb begin
        n_out = r_out;
        if (r_state == ST_DONE) begin
            n_out.window_advance    = r_adv;
            n_out.next_expected_out = r_next[r_peer];
        end else begin
            n_out                   = '0;
            n_out.next_expected_out = r_next[cur_peer];
            if (!i_req.known) begin
                n_out.verdict           = VERD_UNKNOWN;
                n_out.next_expected_out = '0;
            end else if (i_req.func == FUNC_MSG) begin
                if (d_msg >= WINDOW) begin
                    n_out.verdict = VERD_OUTSIDE;
                end else if (r_occ[cur_peer][slot]) begin
                    n_out.verdict = VERD_DUP;
                end else begin
                    n_out.verdict = VERD_ACCEPT;
                    n_out.deliver = 1'b1;
                end
            end else if (i_req.func == FUNC_ACK) begin
                n_out.verdict     = VERD_ACK;
                n_out.newly_acked = acked;
            end else begin
                n_out.verdict = VERD_BADTYPE;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (pop && r_out_valid) n_out_valid = 1'b0;
        if (take && !is_new) n_out_valid = 1'b1;
        if (r_state == ST_DONE) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int p = 0; p < NP; p++) begin
                r_next[p] <= '0;
                r_left[p] <= '0;
                r_occ[p]  <= '0;
                r_ack[p]  <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_out <= n_out;
                        if (is_new) begin
                            // delivered; result waits for the slide
                            r_occ[cur_peer][slot] <= 1'b1;
                            r_peer  <= cur_peer;
                            r_adv   <= '0;
                            r_state <= ST_SLIDE;
                        end
                        if (i_req.known && i_req.func == FUNC_ACK) begin
                            r_ack[cur_peer] <= i_req.seq_value;
                        end
                    end
                end
                ST_SLIDE: begin
                    // one slot of the left edge per cycle
                    if (r_occ[r_peer][r_left[r_peer]]) begin
                        r_occ[r_peer][r_left[r_peer]] <= 1'b0;
                        r_next[r_peer] <= r_next[r_peer] + 32'd1;
                        r_left[r_peer] <= (32'(r_left[r_peer]) == WINDOW - 1) ? '0 :
                                          r_left[r_peer] + SW'(1);
                        r_adv <= r_adv + 7'd1;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_out   <= n_out;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/reliable_receive_window_top.sv -----
// reliable_receive_window_top: selective-repeat receive window, top level.
// Depends on rrw_pkg, rrw_front, rrw_back.
//
// Input queue side: drive i_in_item and push while full is low; one fragment
// is taken per edge with push high and full low.
// Result queue side: while empty is low, o_out_item holds the oldest result;
// pop with empty low takes it. One result per fragment, in order.
// Drops, acks and unknown types pass the front register, then the result
// register. An accepted message walks the window edge one slot per cycle
// in the slide state; the done state writes its result. Sustained rate is
// one fragment per cycle for non-delivering traffic when the receiver pops
// every cycle, since the back takes a request in the cycle its result
// register is popped. Reset clears all peer state (edges, slot maps, ack
// numbers). A stalled receiver holds the result register; the front register
// then fills and full rises.
module reliable_receive_window_top #(
    parameter int unsigned WINDOW = 32,
    parameter int unsigned PEERS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rrw_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output rrw_pkg::t_out_item o_out_item
);
    import rrw_pkg::*;

    logic req_valid, req_ready;
    t_req req;

    rrw_front #(.PEERS(PEERS)) u_front (
        .i_clk, .i_rst_n, .push, .full, .i_item(i_in_item),
        .o_req_valid(req_valid), .i_req_ready(req_ready), .o_req(req)
    );

    rrw_back #(.WINDOW(WINDOW), .PEERS(PEERS)) u_back (
        .i_clk, .i_rst_n, .i_req_valid(req_valid), .o_req_ready(req_ready),
        .i_req(req), .empty, .pop, .o_item(o_out_item)
    );
endmodule

// ----- hw/rtl/rrw_checker.sv -----
// rrw_checker: port-level properties of the receive window, bound to top.
// Depends on rrw_pkg.
module rrw_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input rrw_pkg::t_out_item o_out_item
);
    import rrw_pkg::*;

    a_deliver_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_item.deliver == (o_out_item.verdict == VERD_ACCEPT)))
        else $error("deliver disagrees with verdict");
    a_adv_only_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.deliver) |-> o_out_item.window_advance == 7'd0)
        else $error("advance without delivery");
    a_ack_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.verdict != VERD_ACK) |-> o_out_item.newly_acked == 7'd0)
        else $error("newly_acked on non-ack");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("result changed while stalled");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not clear after reset");
endmodule

bind reliable_receive_window_top rrw_checker u_chk (
    .i_clk, .i_rst_n, .full, .empty, .pop, .o_out_item(o_out_item)
);
